// ----- hdl/itp_pkg.sv -----
// Shared types and constants for the prescaled interval timer.
// Used by itp_core and interval_timer_prescaled; depends on nothing.
`default_nettype none

package itp_pkg;

   // Operation codes carried by an input item.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   // Register offsets.
   localparam logic [2:0] REG_INTERVAL_LO = 3'd0;
   localparam logic [2:0] REG_INTERVAL_HI = 3'd1;
   localparam logic [2:0] REG_COUNT_LO    = 3'd2;
   localparam logic [2:0] REG_COUNT_HI    = 3'd3;
   localparam logic [2:0] REG_CONTROL     = 3'd4;
   localparam logic [2:0] REG_RUN         = 3'd5;

   // Control byte layout.
   localparam int CTRL_WIDTH   = 4;
   localparam int PRESEL_WIDTH = 3;

   // One item held in the input register.
   typedef struct packed {
      op_type      op;
      logic [2:0]  offset;
      logic [7:0]  data;
   } item_type;

   // One result item.
   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_pulse;
   } result_type;

endpackage : itp_pkg

`default_nettype wire

// ----- hdl/interval_timer_prescaled.sv -----
// Top level of the prescaled interval timer: input register, core, result register.
// Depends on itp_pkg and itp_core.
//
// Usage: each transfer on the req_ channel is a timer tick, a byte read or a
// byte write at offsets 0 to 5. Each item gives exactly one transfer on the
// rsp_ channel carrying the read byte (zero for ticks and writes) and the
// interrupt pulse (set only on the tick at which the counter hit the interval).
// Each accepted item is held in the input register and then in the result
// register, from which it is presented on rsp_.
// Throughput: one item per cycle while rsp_stall stays low; the item register feeds
// the timer logic and the result register in one pass, so nothing else limits the rate.
// Stalls: while rsp_stall holds a result, the input register can still take
// one more transfer; after that req_stall rises until the result is taken.
// Reset: synchronous and active high; it empties both registers and clears
// interval, counter, control, run bit and prescaler to zero.
`default_nettype none

module interval_timer_prescaled
   import itp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [2:0] req_reg_offset,
   input  wire logic [7:0] req_write_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_irq_pulse
);

   logic       item_valid_ff, item_valid_in;
   item_type   item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type core_result;
   logic       advance;
   logic       fire;
   logic       req_take;

   // Handshake control between the two registers.
   always_comb begin
      advance       = !rsp_valid_ff || !rsp_stall;
      fire          = item_valid_ff && advance;
      req_stall     = item_valid_ff && !advance;
      req_take      = req_valid && !req_stall;
      item_valid_in = req_take || (item_valid_ff && !fire);
      rsp_valid_in  = fire || (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Input item register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.op     <= op_type'(req_operation);
         item_ff.offset <= req_reg_offset;
         item_ff.data   <= req_write_data;
      end
   end

   // Timer state and item handling.
   itp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .result (core_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_irq_pulse = rsp_ff.irq_pulse;

endmodule : interval_timer_prescaled

`default_nettype wire

// ----- hdl/itp_core.sv -----
// Timer state registers and the single-pass logic that handles one item.
// Depends on itp_pkg.
`default_nettype none

module itp_core
   import itp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire item_type   item,
   output result_type      result
);

   logic [15:0]           interval_ff, interval_in;
   logic [15:0]           count_ff, count_in;
   logic [CTRL_WIDTH-1:0] control_ff, control_in;
   logic                  run_ff, run_in;
   logic [7:0]            prescale_ff, prescale_in;

   logic [7:0]  prescale_next;
   logic [7:0]  prescale_limit;
   logic [15:0] count_next;
   logic        tick_irq;

   // Prescaler and counter advance for a tick.
   always_comb begin
      prescale_next  = prescale_ff + 8'd1;
      prescale_limit = 8'd1 << control_ff[PRESEL_WIDTH-1:0];
      count_next     = count_ff + 16'd1;
   end

   // Next state and result for the item in the input register.
   always_comb begin
      interval_in = interval_ff;
      count_in    = count_ff;
      control_in  = control_ff;
      run_in      = run_ff;
      prescale_in = prescale_ff;
      tick_irq    = 1'b0;
      result      = '0;
      case (item.op)
         OP_TICK: begin
            if (run_ff) begin
               if (prescale_next < prescale_limit) begin
                  prescale_in = prescale_next;
               end else begin
                  prescale_in = '0;
                  if (interval_ff == 16'd0) begin
                     count_in = '0;
                  end else if (count_next >= interval_ff) begin
                     count_in = '0;
                     tick_irq = 1'b1;
                  end else begin
                     count_in = count_next;
                  end
               end
            end
            result.irq_pulse = tick_irq;
         end
         OP_READ: begin
            unique case (item.offset)
               REG_INTERVAL_LO: result.read_data = interval_ff[7:0];
               REG_INTERVAL_HI: result.read_data = interval_ff[15:8];
               REG_COUNT_LO:    result.read_data = count_ff[7:0];
               REG_COUNT_HI:    result.read_data = count_ff[15:8];
               REG_CONTROL:     result.read_data = {{(8-CTRL_WIDTH){1'b0}}, control_ff};
               REG_RUN:         result.read_data = {7'd0, run_ff};
               default:         result.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            unique case (item.offset) inside
               REG_INTERVAL_LO:            interval_in[7:0]  = item.data;
               REG_INTERVAL_HI:            interval_in[15:8] = item.data;
               REG_COUNT_LO, REG_COUNT_HI: count_in          = '0;
               REG_CONTROL:                control_in = item.data[CTRL_WIDTH-1:0];
               REG_RUN:                    run_in            = item.data[0];
               default:                    ;
            endcase
         end
         default: ;
      endcase
   end

   // State registers advance only when the item is handed on.
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         count_ff    <= '0;
         control_ff  <= '0;
         run_ff      <= 1'b0;
         prescale_ff <= '0;
      end else if (fire) begin
         interval_ff <= interval_in;
         count_ff    <= count_in;
         control_ff  <= control_in;
         run_ff      <= run_in;
         prescale_ff <= prescale_in;
      end
   end

endmodule : itp_core

`default_nettype wire
